// ===== rtl/msq_pkg.sv =====
// shared types and constants for the min-extract slot queue
package msq_pkg;

  // request codes
  localparam logic [1:0] ACT_ENQ   = 2'd0;
  localparam logic [1:0] ACT_DEQ   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // fixed field widths
  localparam int ACTION_W   = 2;
  localparam int VALUE_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int IN_TDATA_W = ((ACTION_W + VALUE_W + 7) / 8) * 8;

  // parameter defaults
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 16;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic deq_take;
    logic scan_init;
    logic scan_issue;
    logic commit;
    logic out_load;
  } msq_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic enq_go;
    logic deq_go;
    logic scan_last;
    logic out_free;
  } msq_sts_t;

endpackage

// ===== rtl/min_extract_slot_queue.sv =====
// top level of the min-extract slot queue
//
// A store of CAPACITY slots serving enqueue, dequeue-minimum and clear requests, one result
// transfer per request. Enqueue fills the first emptied slot below the fill mark, else the next
// unused slot; dequeue returns the smallest stored value, the later slot winning on ties. Each
// enqueue into a non-full store and each dequeue from a non-empty one scans every slot through
// the single read port of the value RAM, one slot per cycle; clear, full, empty and the unused
// request code skip the scan. A new request is accepted only after the previous one has loaded
// its result into the output register. A finished result waits in the output register while
// the next request is taken. No clearing pass is needed after reset.
module min_extract_slot_queue #(
  parameter int CAPACITY   = msq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = msq_pkg::DATA_WIDTH_DEF,
  localparam int OCC_W       = $clog2(CAPACITY + 1),
  localparam int OUT_BITS    = msq_pkg::STATUS_W + msq_pkg::VALUE_W + OCC_W,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [msq_pkg::IN_TDATA_W-1:0]    s_tdata,   // action, value_in
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [OUT_TDATA_W-1:0]            m_tdata    // status, value_out, occupancy
);
  import msq_pkg::*;

  msq_ctl_t             ctl;
  msq_sts_t             sts;
  logic [STATUS_W-1:0]  status;
  logic [VALUE_W-1:0]   value_out;
  logic [OCC_W-1:0]     occupancy;

  msq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  msq_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .action     (s_tdata[ACTION_W-1:0]),
    .value_in   (s_tdata[ACTION_W+VALUE_W-1:ACTION_W]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (status),
    .out_value  (value_out),
    .out_occ    (occupancy)
  );

  // result packing, lowest field first
  assign m_tdata = OUT_TDATA_W'({occupancy, value_out, status});

endmodule

// ===== rtl/msq_ram.sv =====
// generic single write port ram with registered read
module msq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/msq_ctrl.sv =====
// request sequencer: accept, dequeue read, slot scan, commit and result hand-off
module msq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  msq_pkg::msq_sts_t  sts,
  output msq_pkg::msq_ctl_t  ctl
);
  import msq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DEQ_TAKE = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_DRAIN    = 3'd3;
  localparam logic [2:0] S_COMMIT   = 3'd4;
  localparam logic [2:0] S_RESULT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // next state and command decode
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          if (sts.enq_go) begin
            ctl.scan_init = 1'b1;
            state_next    = S_SCAN;
          end else if (sts.deq_go) begin
            state_next = S_DEQ_TAKE;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_DEQ_TAKE: begin
        ctl.deq_take  = 1'b1;
        ctl.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        ctl.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        ctl.commit = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/msq_dpath.sv =====
// slot store, valid bits, scan trackers and result register
module msq_dpath #(
  parameter int CAPACITY   = msq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = msq_pkg::DATA_WIDTH_DEF,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int OCC_W = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  msq_pkg::msq_ctl_t             ctl,
  output msq_pkg::msq_sts_t             sts,
  input  logic [msq_pkg::ACTION_W-1:0]  action,
  input  logic [msq_pkg::VALUE_W-1:0]   value_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [msq_pkg::STATUS_W-1:0]  out_status,
  output logic [msq_pkg::VALUE_W-1:0]   out_value,
  output logic [OCC_W-1:0]              out_occ
);
  import msq_pkg::*;

  // request registers
  logic [ACTION_W-1:0]   act;
  logic [DATA_WIDTH-1:0] val;
  logic [STATUS_W-1:0]   status_r;
  logic [VALUE_W-1:0]    value_r;

  // queue bookkeeping
  logic [CAPACITY-1:0]   valid;
  logic [OCC_W-1:0]      used;
  logic [OCC_W-1:0]      count;
  logic [IDX_W-1:0]      min_pos;

  // scan pipeline
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      idx_d;
  logic                  rd_vld;
  logic                  hole_found;
  logic [IDX_W-1:0]      hole_pos;
  logic                  best_found;
  logic [DATA_WIDTH-1:0] best_val;
  logic [IDX_W-1:0]      best_pos;

  // ram ports
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // enqueue placement
  logic [IDX_W-1:0]      enq_pos;
  logic                  enq_is_min;

  assign sts.enq_go    = (action == ACT_ENQ) && (count != OCC_W'(CAPACITY));
  assign sts.deq_go    = (action == ACT_DEQ) && (count != '0);
  assign sts.scan_last = (idx == IDX_W'(CAPACITY - 1));
  assign sts.out_free  = !out_valid || out_ready;

  // outside a scan the read port points at the current minimum
  assign ram_raddr = ctl.scan_issue ? idx : min_pos;
  assign ram_we    = ctl.commit && (act == ACT_ENQ);

  assign enq_pos    = hole_found ? hole_pos : used[IDX_W-1:0];
  assign enq_is_min = !best_found || (val < best_val) ||
                      ((val == best_val) && (enq_pos > best_pos));

  msq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (enq_pos),
    .wdata (val),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request capture and status
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      act      <= action;
      val      <= DATA_WIDTH'(value_in);
      value_r  <= '0;
      status_r <= STAT_OK;
      if ((action == ACT_ENQ) && !sts.enq_go) begin
        status_r <= STAT_FULL;
      end
      if ((action == ACT_DEQ) && !sts.deq_go) begin
        status_r <= STAT_EMPTY;
      end
    end
    if (ctl.deq_take) begin
      value_r <= VALUE_W'(ram_rdata);
    end
  end

  // valid bits, fill level and minimum position
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      used    <= '0;
      count   <= '0;
      min_pos <= '0;
    end else begin
      if (ctl.accept && (action == ACT_CLEAR)) begin
        valid   <= '0;
        used    <= '0;
        count   <= '0;
        min_pos <= '0;
      end
      if (ctl.deq_take) begin
        valid[min_pos] <= 1'b0;
        count          <= count - 1'b1;
      end
      if (ctl.commit) begin
        if (act == ACT_ENQ) begin
          valid[enq_pos] <= 1'b1;
          count          <= count + 1'b1;
          if (!hole_found) begin
            used <= used + 1'b1;
          end
          min_pos <= enq_is_min ? enq_pos : best_pos;
        end else if (best_found) begin
          min_pos <= best_pos;
        end
      end
    end
  end

  // slot scan: first hole below the fill mark and latest smallest value
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      rd_vld     <= 1'b0;
      hole_found <= 1'b0;
      best_found <= 1'b0;
    end else begin
      rd_vld <= ctl.scan_issue;
      if (ctl.scan_init) begin
        idx        <= '0;
        hole_found <= 1'b0;
        best_found <= 1'b0;
      end else if (ctl.scan_issue) begin
        idx <= idx + 1'b1;
      end
      if (rd_vld) begin
        if (!hole_found && !valid[idx_d] && (OCC_W'(idx_d) < used)) begin
          hole_found <= 1'b1;
        end
        if (valid[idx_d] && (!best_found || (ram_rdata <= best_val))) begin
          best_found <= 1'b1;
        end
      end
    end
  end

  // scan payload
  always_ff @(posedge clk) begin
    idx_d <= idx;
    if (rd_vld) begin
      if (!hole_found && !valid[idx_d] && (OCC_W'(idx_d) < used)) begin
        hole_pos <= idx_d;
      end
      if (valid[idx_d] && (!best_found || (ram_rdata <= best_val))) begin
        best_val <= ram_rdata;
        best_pos <= idx_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status <= status_r;
      out_value  <= value_r;
      out_occ    <= count;
    end
  end

  // occupancy matches the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == count)
    else $error("occupancy count differs from valid bits");

  // fill mark bounds the occupancy and the capacity bounds the fill mark
  a_count_le_used: assert property (@(posedge clk) disable iff (rst)
    (count <= used) && (used <= OCC_W'(CAPACITY)))
    else $error("fill mark out of range");

  // between requests a non-empty store points at a live minimum
  a_min_live: assert property (@(posedge clk) disable iff (rst)
    (ctl.accept && (count != '0)) |-> valid[min_pos])
    else $error("minimum position points at an empty slot");

  // a commit never places into an occupied slot
  a_enq_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.commit && (act == ACT_ENQ)) |-> !valid[enq_pos])
    else $error("enqueue into an occupied slot");

endmodule
